/* rtl/mcsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsf_pkg: shared types and constants of the CC / SysEx fader translator
// Opcodes, result status codes, config register indexes, table sizes and
// the command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mcsf_pkg;

    localparam int TABLE_DEPTH    = 16;
    localparam int TEMPLATE_DEPTH = 16;
    localparam int MAX_RESULTS    = 48;

    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int TBL_CW = $clog2(TABLE_DEPTH + 1);
    localparam int TPL_AW = $clog2(TEMPLATE_DEPTH);
    localparam int TPL_CW = $clog2(TEMPLATE_DEPTH + 1);

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 4;
    localparam int NUM_W    = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 5;

    localparam logic [BYTE_W-1:0] CC_STATUS = 8'hB0;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD_ENTRY    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_TEMPLATE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CC_TO_SX      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SX_TO_CC      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP          = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_COUNT         = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_MESSAGE  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOAD_ACK = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COUNT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // config register indexes
    localparam logic [CFG_IW-1:0] CFG_ENTRY_COUNT     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_RECEIVE_CHANNEL = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_SYSEX_LENGTH    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_SYSEX_PARAM_POS = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_SYSEX_VALUE_POS = 3'd4;

    // what the datapath places into the result register
    typedef enum logic [3:0] {
        EMIT_ACK        = 4'd0,
        EMIT_NO_MATCH   = 4'd1,
        EMIT_SYSEX_BYTE = 4'd2,
        EMIT_CC_STATUS  = 4'd3,
        EMIT_CC_NUMBER  = 4'd4,
        EMIT_VALUE      = 4'd5,
        EMIT_LAST_VALUE = 4'd6,
        EMIT_EMPTY      = 4'd7,
        EMIT_COUNT      = 4'd8
    } emit_sel_t;

    typedef struct packed {
        logic      capture;
        logic      do_load;
        logic      inc_i;
        logic      inc_b;
        logic      inc_cnt;
        logic      store_value;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic search_done;
        logic hit;
        logic used_hit;
        logic more_used;
        logic byte_last;
        logic cc_to_sx;
    } dp_stat_t;

endpackage

/* rtl/mcsf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsf_if: request and result channels of the fader translator
// Valid / ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface mcsf_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [3:0] entry_index;
    logic [6:0] cc_number;
    logic [6:0] sysex_number;
    logic [7:0] data_byte;

    modport source (
        output valid, opcode, entry_index, cc_number, sysex_number, data_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, cc_number, sysex_number, data_byte,
        output ready
    );
endinterface

interface mcsf_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_last;
    logic [2:0] status;
    logic [4:0] saved_count;

    modport source (
        output valid, out_byte, is_last, status, saved_count,
        input  ready
    );
    modport sink (
        input  valid, out_byte, is_last, status, saved_count,
        output ready
    );
endinterface

/* rtl/mcsf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsf_ctrl: sequencer of the fader translator
// Takes one request at a time, steps the table scan and the byte emission,
// and only emits when the result register is free.
// ----------------------------------------------------------------------------
module mcsf_ctrl
    import mcsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [OPCODE_W-1:0] req_opcode,
    output logic                req_ready,
    input  dp_stat_t            stat,
    output dp_cmd_t             cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_ACK      = 12'b0000_0000_0010,
        S_SEARCH   = 12'b0000_0000_0100,
        S_SX_BYTES = 12'b0000_0000_1000,
        S_CC_B0    = 12'b0000_0001_0000,
        S_CC_B1    = 12'b0000_0010_0000,
        S_CC_B2    = 12'b0000_0100_0000,
        S_DUMP     = 12'b0000_1000_0000,
        S_DUMP_B0  = 12'b0001_0000_0000,
        S_DUMP_B1  = 12'b0010_0000_0000,
        S_DUMP_B2  = 12'b0100_0000_0000,
        S_COUNT    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    case (req_opcode)
                        OP_LOAD_ENTRY, OP_LOAD_TEMPLATE: state_next = S_ACK;
                        OP_CC_TO_SX, OP_SX_TO_CC:        state_next = S_SEARCH;
                        OP_DUMP:                         state_next = S_DUMP;
                        OP_COUNT:                        state_next = S_COUNT;
                        default:                         state_next = S_IDLE;
                    endcase
                end
            end
            S_ACK:
            begin
                if (stat.out_free)
                begin
                    cmd.do_load   = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_ACK;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_done)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_NO_MATCH;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (stat.hit)
                begin
                    state_next = stat.cc_to_sx ? S_SX_BYTES : S_CC_B0;
                end
                else
                begin
                    cmd.inc_i = 1'b1;
                end
            end
            S_SX_BYTES:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_SYSEX_BYTE;
                    cmd.emit_last = stat.byte_last;
                    cmd.inc_b     = 1'b1;
                    if (stat.byte_last)
                    begin
                        cmd.store_value = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_CC_B0:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_CC_STATUS;
                    state_next   = S_CC_B1;
                end
            end
            S_CC_B1:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_CC_NUMBER;
                    state_next   = S_CC_B2;
                end
            end
            S_CC_B2:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_sel    = EMIT_VALUE;
                    cmd.emit_last   = 1'b1;
                    cmd.store_value = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // reaching the end here means no used entry was found
                if (stat.search_done)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_EMPTY;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (stat.used_hit)
                begin
                    state_next = S_DUMP_B0;
                end
                else
                begin
                    cmd.inc_i = 1'b1;
                end
            end
            S_DUMP_B0:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_CC_STATUS;
                    state_next   = S_DUMP_B1;
                end
            end
            S_DUMP_B1:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_CC_NUMBER;
                    state_next   = S_DUMP_B2;
                end
            end
            S_DUMP_B2:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_LAST_VALUE;
                    cmd.emit_last = !stat.more_used;
                    cmd.inc_i     = 1'b1;
                    state_next    = stat.more_used ? S_DUMP : S_IDLE;
                end
            end
            S_COUNT:
            begin
                if (stat.search_done)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_COUNT;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.inc_cnt = stat.used_hit;
                    cmd.inc_i   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/mcsf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcsf_dp: datapath of the fader translator
// Config registers, entry table, SysEx template, scan and byte counters,
// and the result register.
// ----------------------------------------------------------------------------
module mcsf_dp
    import mcsf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic [OPCODE_W-1:0] req_opcode,
    input  logic [INDEX_W-1:0]  req_entry_index,
    input  logic [NUM_W-1:0]    req_cc_number,
    input  logic [NUM_W-1:0]    req_sysex_number,
    input  logic [BYTE_W-1:0]   req_data_byte,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output logic [BYTE_W-1:0]   rsp_out_byte,
    output logic                rsp_is_last,
    output logic [STATUS_W-1:0] rsp_status,
    output logic [COUNT_W-1:0]  rsp_saved_count
);

    // config
    logic [4:0] entry_count_reg;
    logic [4:0] receive_channel_reg;
    logic [4:0] sysex_length_reg;
    logic [3:0] sysex_param_pos_reg;
    logic [3:0] sysex_value_pos_reg;

    // captured request
    logic [OPCODE_W-1:0] op_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [NUM_W-1:0]    cc_reg;
    logic [NUM_W-1:0]    sx_reg;
    logic [BYTE_W-1:0]   val_reg;

    // tables
    logic [NUM_W-1:0]  entry_cc_reg    [TABLE_DEPTH];
    logic [NUM_W-1:0]  entry_sx_reg    [TABLE_DEPTH];
    logic [NUM_W-1:0]  entry_last_reg  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] used_reg;
    logic [BYTE_W-1:0] template_reg    [TEMPLATE_DEPTH];

    // counters
    logic [TBL_CW-1:0] i_reg;
    logic [TBL_CW-1:0] i_next;
    logic [TPL_CW-1:0] b_reg;
    logic [TPL_CW-1:0] b_next;
    logic [TBL_CW-1:0] cnt_reg;
    logic [TBL_CW-1:0] cnt_next;

    // result register
    logic                rsp_valid_reg;
    logic [BYTE_W-1:0]   rsp_byte_reg;
    logic                rsp_last_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [COUNT_W-1:0]  rsp_saved_reg;
    logic [BYTE_W-1:0]   rsp_byte_next;
    logic [STATUS_W-1:0] rsp_status_next;
    logic [COUNT_W-1:0]  rsp_saved_next;

    logic [TBL_CW-1:0] n_active;
    logic [TPL_CW-1:0] msg_len;
    logic [TBL_AW-1:0] ent_addr;
    logic [TPL_AW-1:0] tpl_addr;
    logic [TBL_AW-1:0] load_addr;
    logic [TPL_AW-1:0] load_tpl_addr;
    logic [BYTE_W-1:0] cc_status_byte;
    logic [BYTE_W-1:0] sysex_byte;
    logic [TABLE_DEPTH-1:0] live_used;
    logic              more_used;
    logic [3:0]        chan_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg     <= 5'd0;
            receive_channel_reg <= 5'd1;
            sysex_length_reg    <= 5'd1;
            sysex_param_pos_reg <= 4'd0;
            sysex_value_pos_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT:     entry_count_reg     <= cfg_data;
                CFG_RECEIVE_CHANNEL: receive_channel_reg <= cfg_data;
                CFG_SYSEX_LENGTH:    sysex_length_reg    <= cfg_data;
                CFG_SYSEX_PARAM_POS: sysex_param_pos_reg <= cfg_data[3:0];
                CFG_SYSEX_VALUE_POS: sysex_value_pos_reg <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_opcode;
            idx_reg <= req_entry_index;
            cc_reg  <= req_cc_number;
            sx_reg  <= req_sysex_number;
            val_reg <= req_data_byte;
        end
    end

    // active entries and message length, clamped to the stores
    always_comb
    begin
        if (int'(entry_count_reg) > TABLE_DEPTH)
            n_active = TBL_CW'(TABLE_DEPTH);
        else
            n_active = TBL_CW'(entry_count_reg);

        if (sysex_length_reg == 5'd0)
            msg_len = TPL_CW'(1);
        else if (int'(sysex_length_reg) > TEMPLATE_DEPTH)
            msg_len = TPL_CW'(TEMPLATE_DEPTH);
        else
            msg_len = TPL_CW'(sysex_length_reg);
        if (int'(msg_len) > MAX_RESULTS)
            msg_len = TPL_CW'(MAX_RESULTS);
    end

    assign ent_addr      = i_reg[TBL_AW-1:0];
    assign tpl_addr      = b_reg[TPL_AW-1:0];
    assign load_addr     = TBL_AW'(idx_reg);
    assign load_tpl_addr = TPL_AW'(idx_reg);

    // entry payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.do_load && op_reg == OP_LOAD_ENTRY && int'(idx_reg) < TABLE_DEPTH)
        begin
            entry_cc_reg[load_addr] <= cc_reg;
            entry_sx_reg[load_addr] <= sx_reg;
        end
        if (cmd.store_value)
        begin
            entry_last_reg[ent_addr] <= val_reg[NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int k = 0; k < TEMPLATE_DEPTH; k++)
            begin
                template_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.do_load && op_reg == OP_LOAD_ENTRY && int'(idx_reg) < TABLE_DEPTH)
            begin
                used_reg[load_addr] <= 1'b0;
            end
            if (cmd.do_load && op_reg == OP_LOAD_TEMPLATE
                && int'(idx_reg) < TEMPLATE_DEPTH)
            begin
                template_reg[load_tpl_addr] <= val_reg;
            end
            if (cmd.store_value)
            begin
                used_reg[ent_addr] <= 1'b1;
            end
        end
    end

    // scan, byte and count counters
    always_comb
    begin
        i_next   = i_reg;
        b_next   = b_reg;
        cnt_next = cnt_reg;
        if (cmd.capture)
        begin
            i_next   = '0;
            b_next   = '0;
            cnt_next = '0;
        end
        else
        begin
            if (cmd.inc_i)
                i_next = i_reg + TBL_CW'(1);
            if (cmd.inc_b)
                b_next = b_reg + TPL_CW'(1);
            if (cmd.inc_cnt)
                cnt_next = cnt_reg + TBL_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            b_reg   <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            i_reg   <= i_next;
            b_reg   <= b_next;
            cnt_reg <= cnt_next;
        end
    end

    // used entries inside the active range, and whether one lies past the scan point
    always_comb
    begin
        more_used = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            live_used[k] = used_reg[k] && (k < int'(n_active));
            if (live_used[k] && k > int'(i_reg))
                more_used = 1'b1;
        end
    end

    assign chan_low       = 4'(receive_channel_reg - 5'd1);
    assign cc_status_byte = CC_STATUS + {4'd0, chan_low};

    // value position wins over parameter position
    always_comb
    begin
        if (b_reg == TPL_CW'(sysex_value_pos_reg))
            sysex_byte = val_reg;
        else if (b_reg == TPL_CW'(sysex_param_pos_reg))
            sysex_byte = {1'b0, entry_sx_reg[ent_addr]};
        else
            sysex_byte = template_reg[tpl_addr];
    end

    always_comb
    begin
        stat.out_free    = !rsp_valid_reg || rsp_ready;
        stat.search_done = i_reg >= n_active;
        stat.cc_to_sx    = op_reg == OP_CC_TO_SX;
        stat.hit         = (op_reg == OP_CC_TO_SX) ? (entry_cc_reg[ent_addr] == cc_reg)
                                                   : (entry_sx_reg[ent_addr] == sx_reg);
        stat.used_hit    = used_reg[ent_addr];
        stat.more_used   = more_used;
        stat.byte_last   = (b_reg + TPL_CW'(1)) == msg_len;
    end

    always_comb
    begin
        rsp_byte_next   = '0;
        rsp_status_next = ST_MESSAGE;
        rsp_saved_next  = '0;
        case (cmd.emit_sel)
            EMIT_ACK:        rsp_status_next = ST_LOAD_ACK;
            EMIT_NO_MATCH:   rsp_status_next = ST_NO_MATCH;
            EMIT_SYSEX_BYTE: rsp_byte_next   = sysex_byte;
            EMIT_CC_STATUS:  rsp_byte_next   = cc_status_byte;
            EMIT_CC_NUMBER:  rsp_byte_next   = {1'b0, entry_cc_reg[ent_addr]};
            EMIT_VALUE:      rsp_byte_next   = val_reg;
            EMIT_LAST_VALUE: rsp_byte_next   = {1'b0, entry_last_reg[ent_addr]};
            EMIT_EMPTY:      rsp_status_next = ST_EMPTY;
            EMIT_COUNT:
            begin
                rsp_status_next = ST_COUNT;
                rsp_saved_next  = COUNT_W'(cnt_reg);
            end
            default:         rsp_status_next = ST_MESSAGE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_byte_reg   <= rsp_byte_next;
            rsp_last_reg   <= cmd.emit_last;
            rsp_status_reg <= rsp_status_next;
            rsp_saved_reg  <= rsp_saved_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_out_byte    = rsp_byte_reg;
    assign rsp_is_last     = rsp_last_reg;
    assign rsp_status      = rsp_status_reg;
    assign rsp_saved_count = rsp_saved_reg;

endmodule

/* rtl/midi_cc_sysex_fader_translator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_cc_sysex_fader_translator_core: MIDI CC <-> SysEx fader translator
// Request channel req carries one command; result channel rsp carries one
// message byte or status per transfer, is_last marking the final one.
// The user must write the config port (cfg_we, cfg_index, cfg_data) only
// while idle; the block does not enforce it. One request is handled at a
// time; req.ready is high only when idle. Loads: 1 result, an acknowledge.
// CC to SysEx / SysEx to CC: linear scan of the entry table, one entry per
// cycle (up to 16 entries), then one byte per cycle while rsp accepts them
// (sysex_length bytes, clamped to 1..16, or 3). Dump: 3 bytes per used entry.
// Count: scans each active entry, then 1 result.
// The scan counter paces scans; the single result register paces emission.
// The result register holds while rsp.ready is low; the sequencer then waits.
// Reset clears config to defaults, used marks and the SysEx template; entry
// numbers and last values are undefined until loaded.
// ----------------------------------------------------------------------------
module midi_cc_sysex_fader_translator_core
    import mcsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    mcsf_req_if.sink          req,
    mcsf_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     req_ready;

    assign req.ready = req_ready;

    mcsf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    mcsf_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_opcode       (req.opcode),
        .req_entry_index  (req.entry_index),
        .req_cc_number    (req.cc_number),
        .req_sysex_number (req.sysex_number),
        .req_data_byte    (req.data_byte),
        .cmd              (cmd),
        .stat             (stat),
        .rsp_ready        (rsp.ready),
        .rsp_valid        (rsp.valid),
        .rsp_out_byte     (rsp.out_byte),
        .rsp_is_last      (rsp.is_last),
        .rsp_status       (rsp.status),
        .rsp_saved_count  (rsp.saved_count)
    );

endmodule
